// ----- rtl/core/bltok_pkg.sv -----
// ----------------------------------------------------------------------------
// bltok_pkg
// Shared types, codes and helpers for the bracket list tokenizer.
// ----------------------------------------------------------------------------
package bltok_pkg;

  // Limits of the design.
  localparam int unsigned MAX_BYTES = 65536;
  localparam int unsigned MAX_ATOMS = 8192;
  localparam int unsigned MAX_LISTS = 2048;

  // Field widths.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned OFF_W    = 16;
  localparam int unsigned LEN_W    = 17;
  localparam int unsigned DEPTH_W  = 12;
  localparam int unsigned ATOM_W   = 14;
  localparam int unsigned ERR_W    = 3;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ATOM_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LIST_LIMIT = CFG_IDX_W'(1);

  localparam logic [ATOM_W-1:0]  ATOM_LIMIT_RST = ATOM_W'(MAX_ATOMS);
  localparam logic [DEPTH_W-1:0] LIST_LIMIT_RST = DEPTH_W'(MAX_LISTS);

  // Event kinds.
  localparam logic [KIND_W-1:0] KIND_ATOM  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TUPLE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OPEN  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLOSE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DONE  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ERROR = 3'd5;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE         = 3'd0;
  localparam logic [ERR_W-1:0] ERR_UNCLOSED_LST = 3'd1;
  localparam logic [ERR_W-1:0] ERR_UNCLOSED_TPL = 3'd2;
  localparam logic [ERR_W-1:0] ERR_LISTS        = 3'd3;
  localparam logic [ERR_W-1:0] ERR_ATOMS        = 3'd4;
  localparam logic [ERR_W-1:0] ERR_STRAY_CLOSE  = 3'd5;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG     = 3'd6;

  // Characters.
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRK  = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAR  = 8'h29;

  // Scanner state.
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_ATOM  = 3'b010,
    MODE_TUPLE = 3'b100
  } mode_e;

  // One result word.
  typedef struct packed {
    logic [KIND_W-1:0]  event_kind;
    logic [OFF_W-1:0]   byte_offset;
    logic [LEN_W-1:0]   token_length;
    logic [DEPTH_W-1:0] nest_depth;
    logic [ATOM_W-1:0]  atom_total;
    logic [ERR_W-1:0]   error_code;
    logic               end_of_source;
  } res_t;

  function automatic logic is_space(input logic [BYTE_W-1:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
           (b == CH_CR) || (b == CH_NUL);
  endfunction

  function automatic res_t make_res(input logic [KIND_W-1:0]  kind,
                                    input logic [OFF_W-1:0]   off,
                                    input logic [LEN_W-1:0]   len,
                                    input logic [DEPTH_W-1:0] depth,
                                    input logic [ATOM_W-1:0]  atoms,
                                    input logic [ERR_W-1:0]   err,
                                    input logic               eos);
    res_t r;
    r.event_kind    = kind;
    r.byte_offset   = off;
    r.token_length  = len;
    r.nest_depth    = depth;
    r.atom_total    = atoms;
    r.error_code    = err;
    r.end_of_source = eos;
    return r;
  endfunction

endpackage

// ----- rtl/core/bltok_ifs.sv -----
// ----------------------------------------------------------------------------
// bltok channel interfaces
// Valid/ready channels for source bytes, token words and register writes.
// ----------------------------------------------------------------------------
interface bltok_in_if;
  logic                        valid;
  logic                        ready;
  logic [bltok_pkg::BYTE_W-1:0] data_byte;
  logic                        last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bltok_out_if;
  logic                          valid;
  logic                          ready;
  logic [bltok_pkg::KIND_W-1:0]  event_kind;
  logic [bltok_pkg::OFF_W-1:0]   byte_offset;
  logic [bltok_pkg::LEN_W-1:0]   token_length;
  logic [bltok_pkg::DEPTH_W-1:0] nest_depth;
  logic [bltok_pkg::ATOM_W-1:0]  atom_total;
  logic [bltok_pkg::ERR_W-1:0]   error_code;
  logic                          end_of_source;

  modport source (output valid, output event_kind, output byte_offset,
                  output token_length, output nest_depth, output atom_total,
                  output error_code, output end_of_source, input ready);
  modport sink   (input valid, input event_kind, input byte_offset,
                  input token_length, input nest_depth, input atom_total,
                  input error_code, input end_of_source, output ready);
endinterface

interface bltok_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bltok_pkg::CFG_IDX_W-1:0]  index;
  logic [bltok_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/bracket_list_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// bracket_list_tokenizer_core
// Streaming tokenizer for bracketed list text, one source byte per cycle while the output keeps up.
// ----------------------------------------------------------------------------
// Order: a byte is registered when accepted and scanned from the input register
//   once the result slots can take its words; those words are registered in the
//   result slots, and slot 0 drives the output.
// Throughput: one byte per cycle while each byte yields at most one word and the output is ready;
//   a byte that yields k words (k up to 3) holds the result slots until all k are taken.
// Reset: clears the scanner to the start of a new source, empties the
//   pipeline and sets the atom and list limits to 8192 and 2048.
module bracket_list_tokenizer_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bltok_in_if.sink             in_i,
  bltok_cfg_if.sink            cfg_i,
  bltok_out_if.source          out_o
);

  // Limit registers.
  logic [bltok_pkg::ATOM_W-1:0]  atom_limit_q;
  logic [bltok_pkg::DEPTH_W-1:0] list_limit_q;

  // Input register.
  logic                          in_vld_q;
  logic [bltok_pkg::BYTE_W-1:0]  in_byte_q;
  logic                          in_last_q;

  // Scanner state.
  bltok_pkg::mode_e              mode_q, mode_d;
  logic [bltok_pkg::OFF_W-1:0]   ts_q, ts_d;
  logic [bltok_pkg::LEN_W-1:0]   bc_q, bc_d;
  logic [bltok_pkg::DEPTH_W-1:0] dep_q, dep_d;
  logic [bltok_pkg::ATOM_W-1:0]  at_q, at_d;
  logic [bltok_pkg::DEPTH_W-1:0] ls_q, ls_d;
  logic                          fl_q, fl_d;

  // Result slots; slot 0 drives the output.
  bltok_pkg::res_t               slot_q [3];
  bltok_pkg::res_t               res    [3];
  logic [1:0]                    cnt_q;
  logic [1:0]                    n;

  logic                          pop;
  logic                          proc;
  logic [bltok_pkg::ATOM_W-1:0]  lim_a;
  logic [bltok_pkg::DEPTH_W-1:0] lim_l;
  logic [bltok_pkg::LEN_W-1:0]   idx;
  logic [bltok_pkg::OFF_W-1:0]   off;
  logic                          taken;

  assign pop   = out_o.valid && out_o.ready;
  assign proc  = in_vld_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));
  assign in_i.ready  = !in_vld_q || proc;
  assign cfg_i.ready = 1'b1;

  assign lim_a = (atom_limit_q > bltok_pkg::ATOM_LIMIT_RST) ?
                 bltok_pkg::ATOM_LIMIT_RST : atom_limit_q;
  assign lim_l = (list_limit_q > bltok_pkg::LIST_LIMIT_RST) ?
                 bltok_pkg::LIST_LIMIT_RST : list_limit_q;

  assign idx = bc_q;
  assign off = idx[bltok_pkg::OFF_W-1:0];

  // Scan of one byte: the same order of checks as the token rules.
  always_comb begin
    mode_d = mode_q;
    ts_d   = ts_q;
    bc_d   = bc_q;
    dep_d  = dep_q;
    at_d   = at_q;
    ls_d   = ls_q;
    fl_d   = fl_q;
    n      = 2'd0;
    taken  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end

    if (fl_q) begin
      // Bytes after an error are dropped until the last one.
    end else if (idx[bltok_pkg::LEN_W-1]) begin
      res[n] = bltok_pkg::make_res(bltok_pkg::KIND_ERROR, off, '0, dep_d, at_d,
                                   bltok_pkg::ERR_TOO_LONG, 1'b1);
      n    = n + 2'd1;
      fl_d = 1'b1;
    end else begin
      unique case (mode_q)
        bltok_pkg::MODE_TUPLE: begin
          taken = 1'b1;
          if (in_byte_q == bltok_pkg::CH_RPAR) begin
            at_d = at_d + bltok_pkg::ATOM_W'(1);
            if (at_d > lim_a) begin
              res[n] = bltok_pkg::make_res(bltok_pkg::KIND_ERROR, off, '0, dep_d,
                                           at_d, bltok_pkg::ERR_ATOMS, 1'b1);
              fl_d = 1'b1;
            end else begin
              res[n] = bltok_pkg::make_res(bltok_pkg::KIND_TUPLE, ts_d,
                                           idx + bltok_pkg::LEN_W'(1) - {1'b0, ts_d},
                                           dep_d, at_d, bltok_pkg::ERR_NONE, 1'b0);
            end
            n      = n + 2'd1;
            mode_d = bltok_pkg::MODE_IDLE;
          end
        end
        bltok_pkg::MODE_ATOM: begin
          if (bltok_pkg::is_space(in_byte_q) || (in_byte_q == bltok_pkg::CH_LBRK) ||
              (in_byte_q == bltok_pkg::CH_RBRK)) begin
            at_d = at_d + bltok_pkg::ATOM_W'(1);
            if (at_d > lim_a) begin
              res[n] = bltok_pkg::make_res(bltok_pkg::KIND_ERROR, off, '0, dep_d,
                                           at_d, bltok_pkg::ERR_ATOMS, 1'b1);
              fl_d = 1'b1;
            end else begin
              res[n] = bltok_pkg::make_res(bltok_pkg::KIND_ATOM, ts_d,
                                           idx - {1'b0, ts_d}, dep_d, at_d,
                                           bltok_pkg::ERR_NONE, 1'b0);
            end
            n      = n + 2'd1;
            mode_d = bltok_pkg::MODE_IDLE;
          end else begin
            taken = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (!taken && !fl_d) begin
        if (bltok_pkg::is_space(in_byte_q)) begin
          // Separator.
        end else if (in_byte_q == bltok_pkg::CH_LBRK) begin
          ls_d = ls_d + bltok_pkg::DEPTH_W'(1);
          if (ls_d > lim_l) begin
            res[n] = bltok_pkg::make_res(bltok_pkg::KIND_ERROR, off, '0, dep_d, at_d,
                                         bltok_pkg::ERR_LISTS, 1'b1);
            fl_d   = 1'b1;
          end else begin
            at_d = at_d + bltok_pkg::ATOM_W'(1);
            if (at_d > lim_a) begin
              res[n] = bltok_pkg::make_res(bltok_pkg::KIND_ERROR, off, '0, dep_d,
                                           at_d, bltok_pkg::ERR_ATOMS, 1'b1);
              fl_d   = 1'b1;
            end else begin
              dep_d  = dep_d + bltok_pkg::DEPTH_W'(1);
              res[n] = bltok_pkg::make_res(bltok_pkg::KIND_OPEN, off,
                                           bltok_pkg::LEN_W'(1), dep_d, at_d,
                                           bltok_pkg::ERR_NONE, 1'b0);
            end
          end
          n = n + 2'd1;
        end else if (in_byte_q == bltok_pkg::CH_RBRK) begin
          if (dep_d == '0) begin
            res[n] = bltok_pkg::make_res(bltok_pkg::KIND_ERROR, off, '0, dep_d, at_d,
                                         bltok_pkg::ERR_STRAY_CLOSE, 1'b1);
            fl_d   = 1'b1;
          end else begin
            dep_d  = dep_d - bltok_pkg::DEPTH_W'(1);
            res[n] = bltok_pkg::make_res(bltok_pkg::KIND_CLOSE, off,
                                         bltok_pkg::LEN_W'(1), dep_d, at_d,
                                         bltok_pkg::ERR_NONE, 1'b0);
          end
          n = n + 2'd1;
        end else begin
          mode_d = (in_byte_q == bltok_pkg::CH_LPAR) ? bltok_pkg::MODE_TUPLE :
                                                       bltok_pkg::MODE_ATOM;
          ts_d   = off;
        end
      end

      bc_d = idx + bltok_pkg::LEN_W'(1);

      // End of source: an open tuple wins over an open list.
      if (in_last_q && !fl_d) begin
        if (mode_d == bltok_pkg::MODE_TUPLE) begin
          res[n] = bltok_pkg::make_res(bltok_pkg::KIND_ERROR, off, '0, dep_d, at_d,
                                       bltok_pkg::ERR_UNCLOSED_TPL, 1'b1);
          n      = n + 2'd1;
          fl_d   = 1'b1;
        end else begin
          if (mode_d == bltok_pkg::MODE_ATOM) begin
            at_d = at_d + bltok_pkg::ATOM_W'(1);
            if (at_d > lim_a) begin
              res[n] = bltok_pkg::make_res(bltok_pkg::KIND_ERROR, off, '0, dep_d,
                                           at_d, bltok_pkg::ERR_ATOMS, 1'b1);
              fl_d   = 1'b1;
            end else begin
              res[n] = bltok_pkg::make_res(bltok_pkg::KIND_ATOM, ts_d,
                                           bc_d - {1'b0, ts_d}, dep_d, at_d,
                                           bltok_pkg::ERR_NONE, 1'b0);
            end
            n      = n + 2'd1;
            mode_d = bltok_pkg::MODE_IDLE;
          end
          if (!fl_d) begin
            if (dep_d != '0) begin
              res[n] = bltok_pkg::make_res(bltok_pkg::KIND_ERROR, off, '0, dep_d,
                                           at_d, bltok_pkg::ERR_UNCLOSED_LST, 1'b1);
              fl_d   = 1'b1;
            end else begin
              res[n] = bltok_pkg::make_res(bltok_pkg::KIND_DONE, '0, bc_d, dep_d,
                                           at_d, bltok_pkg::ERR_NONE, 1'b1);
            end
            n = n + 2'd1;
          end
        end
      end
    end

    // The last byte always starts a fresh source.
    if (in_last_q) begin
      mode_d = bltok_pkg::MODE_IDLE;
      ts_d   = '0;
      bc_d   = '0;
      dep_d  = '0;
      at_d   = '0;
      ls_d   = bltok_pkg::DEPTH_W'(1);
      fl_d   = 1'b0;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atom_limit_q <= bltok_pkg::ATOM_LIMIT_RST;
      list_limit_q <= bltok_pkg::LIST_LIMIT_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.index == bltok_pkg::REG_ATOM_LIMIT) begin
        atom_limit_q <= cfg_i.data[bltok_pkg::ATOM_W-1:0];
      end else if (cfg_i.index == bltok_pkg::REG_LIST_LIMIT) begin
        list_limit_q <= cfg_i.data[bltok_pkg::DEPTH_W-1:0];
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  // Scanner state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= bltok_pkg::MODE_IDLE;
      ts_q   <= '0;
      bc_q   <= '0;
      dep_q  <= '0;
      at_q   <= '0;
      ls_q   <= bltok_pkg::DEPTH_W'(1);
      fl_q   <= 1'b0;
    end else if (proc) begin
      mode_q <= mode_d;
      ts_q   <= ts_d;
      bc_q   <= bc_d;
      dep_q  <= dep_d;
      at_q   <= at_d;
      ls_q   <= ls_d;
      fl_q   <= fl_d;
    end
  end

  // Result slots: a new byte reloads them, otherwise a pop shifts them down.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (proc) begin
      cnt_q <= n;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      slot_q[0] <= res[0];
      slot_q[1] <= res[1];
      slot_q[2] <= res[2];
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
      slot_q[1] <= slot_q[2];
    end
  end

  assign out_o.valid         = (cnt_q != 2'd0);
  assign out_o.event_kind    = slot_q[0].event_kind;
  assign out_o.byte_offset   = slot_q[0].byte_offset;
  assign out_o.token_length  = slot_q[0].token_length;
  assign out_o.nest_depth    = slot_q[0].nest_depth;
  assign out_o.atom_total    = slot_q[0].atom_total;
  assign out_o.error_code    = slot_q[0].error_code;
  assign out_o.end_of_source = slot_q[0].end_of_source;

`ifndef ASSERT_OFF
  // Every open list was counted, so the depth stays below the list count.
  a_depth_below_lists: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dep_q < ls_q)
    else $error("nesting depth reached the list count");

  // A scanned last byte leaves the scanner at the start of a new source.
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_last_q |=> (bc_q == '0) && (dep_q == '0) && !fl_q)
    else $error("scanner state not cleared after the last byte");

  // A held byte is only scanned once the result slots drain.
  a_hold_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && (cnt_q > 2'd1) |-> !proc && !in_i.ready)
    else $error("byte scanned while results were still pending");
`endif

endmodule
